>>> rtl/itda_pkg.sv
`default_nettype none

package itda_pkg;

   // ascii codes
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // one packed bcd digit
   localparam int unsigned DIGIT_W = 4;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

endpackage : itda_pkg

`default_nettype wire

>>> rtl/int_to_decimal_ascii_top.sv
`default_nettype none

// signed integer to decimal ascii text, one character per output transaction
//
// req channel: one transaction carries one signed VALUE_WIDTH-bit integer
// in the low bits of req_tdata. rsp channel: one transaction per character,
// most significant first; a negative number starts with '-', zero prints as
// a single '0', and rsp_tlast marks the final digit of each number.
//
// the magnitude goes through a bit-serial double-dabble unit (add-3 on every
// bcd digit of 5 or more, then shift one binary bit in). the bcd word is then
// stripped of its leading zero digits, and the text leaves at one character
// per cycle while rsp_tready is high.
// the block holds one number at a time; req_tready is high only when idle.
//
// reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_tvalid; a number in flight is discarded. when the receiver stalls,
// the current character and rsp_tlast hold steady until taken.

module int_to_decimal_ascii_top
   import itda_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,  // value
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [7:0]                             rsp_tdata,  // character
   output logic                                   rsp_tlast   // last
);

   // decimal digits needed for 2^VALUE_WIDTH - 1, log10(2) ~ 0.30103
   localparam int unsigned DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int unsigned BCD_W  = DIGITS * DIGIT_W;
   localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned NDIG_W = $clog2(DIGITS + 1);

   state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic [BCD_W-1:0]         bcd_ff, bcd_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [NDIG_W-1:0]        ndig_ff, ndig_in;

   logic [VALUE_WIDTH-1:0]   value;
   logic [BCD_W-1:0]         bcd_adj;
   logic [DIGIT_W-1:0]       top_digit;
   logic                     req_fire;
   logic                     rsp_fire;
   logic                     one_digit_left;

   assign value          = req_tdata[VALUE_WIDTH-1:0];
   assign top_digit      = bcd_ff[BCD_W-1 -: DIGIT_W];
   assign req_fire       = req_tvalid & req_tready;
   assign rsp_fire       = rsp_tvalid & rsp_tready;
   assign one_digit_left = (ndig_ff == NDIG_W'(1));

   // add-3 correction on every bcd digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < int'(DIGITS); i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end else begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            // stop at the first nonzero digit, or keep a lone zero
            if (top_digit != '0 || one_digit_left) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (rsp_fire) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (rsp_fire && one_digit_left) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      ndig_in = ndig_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in = value[VALUE_WIDTH-1];
               mag_in = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
               bcd_in = '0;
               cnt_in = CNT_W'(VALUE_WIDTH);
            end
         end
         ST_CONVERT: begin
            bcd_in  = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in  = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            ndig_in = NDIG_W'(DIGITS);
         end
         ST_STRIP: begin
            if (top_digit == '0 && !one_digit_left) begin
               bcd_in  = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               ndig_in = ndig_ff - NDIG_W'(1);
            end
         end
         ST_DIGIT: begin
            if (rsp_fire) begin
               bcd_in  = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               ndig_in = ndig_ff - NDIG_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tdata  = CHAR_ZERO + {4'b0000, top_digit};
      rsp_tlast  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SIGN: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = CHAR_MINUS;
         end
         ST_DIGIT: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = one_digit_left;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      ndig_ff <= ndig_in;
   end

endmodule : int_to_decimal_ascii_top

`default_nettype wire

>>> tb/int_to_decimal_ascii_top_tb.sv
`timescale 1ns / 1ps

module int_to_decimal_ascii_top_tb
   import itda_pkg::*;
();

   localparam int unsigned VALUE_WIDTH   = 32;
   localparam int unsigned DATA_W        = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int unsigned DECIMAL_RADIX = 10;
   localparam int unsigned RANDOM_ITEMS  = 200;
   localparam int unsigned CALM_ITEMS    = 40;   // tail of the run with no idling
   localparam int unsigned DRAIN_CYCLES  = 60;   // a little more than one conversion

   // one character of expected text
   typedef struct {
      logic [7:0] code;
      logic       last;
   } text_char_type;

   // directed stimulus: empty text means the expected text comes from the predictor
   typedef struct {
      logic [VALUE_WIDTH-1:0] value;
      string                  text;
   } number_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;    // value
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;    // character
   logic              rsp_tlast;    // last

   text_char_type pending_text[$];  // characters still owed by the block
   int unsigned   mismatch_count;
   bit            idle_on;          // random gaps and stalls allowed
   int unsigned   rsp_hold;         // stall cycles left on the receive side

   number_row_type number_table[20] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{-32'sd1,        "-1"},
      '{32'd9,          "9"},
      '{-32'sd9,        "-9"},
      '{32'd10,         "10"},
      '{-32'sd10,       "-10"},
      '{32'd99,         ""},
      '{32'd100,        ""},
      '{32'd2147483647, "2147483647"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd1000000000, "1000000000"},
      '{-32'sd1000000000, "-1000000000"},
      '{32'd999999999,  ""},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'd12345,      ""},
      '{-32'sd67890,    ""},
      '{32'd0,          "0"}
   };

   int_to_decimal_ascii_top #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t: mismatch: %s", $realtime, what);
   endtask

   // decimal text of a signed value; the magnitude is taken unsigned so the
   // most negative value needs no special handling
   function automatic void predict_decimal_text(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [7:0]             digits[$];
      bit                     negative;
      negative  = value[VALUE_WIDTH-1];
      magnitude = negative ? (~value + 1'b1) : value;
      do begin
         digits.push_front(CHAR_ZERO + 8'(magnitude % DECIMAL_RADIX));
         magnitude = magnitude / DECIMAL_RADIX;
      end while (magnitude != 0);
      if (negative) begin
         pending_text.push_back('{CHAR_MINUS, 1'b0});
      end
      foreach (digits[i]) begin
         pending_text.push_back('{digits[i], 1'(i == digits.size() - 1)});
      end
   endfunction

   // text typed into the table, last flag on its final character
   function automatic void queue_typed_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         pending_text.push_back('{8'(text[i]), 1'(i == text.len() - 1)});
      end
   endfunction

   // one request transaction, optionally preceded by an idle burst
   task automatic send_number(input logic [VALUE_WIDTH-1:0] value, input string text);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(value);
      do @(posedge clock); while (!req_tready);
      if (text.len() != 0) begin
         queue_typed_text(text);
      end else begin
         predict_decimal_text(value);
      end
   endtask

   // hold off the sender until the block has emitted everything owed
   task automatic drain_text;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_text.size() != 0) @(posedge clock);
   endtask

   // random values spread over all text lengths, both signs and the edges
   function automatic logic [VALUE_WIDTH-1:0] pick_value;
      longint unsigned        span;
      logic [VALUE_WIDTH-1:0] magnitude;
      int unsigned            ndigits;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: begin
            ndigits = $urandom_range(1, 10);
            span    = 1;
            repeat (ndigits) span = span * DECIMAL_RADIX;
            magnitude = VALUE_WIDTH'((longint'($urandom) << 1 | $urandom_range(0, 1)) % span);
            if (magnitude > 32'h8000_0000) magnitude = magnitude & 32'h7FFF_FFFF;
            return $urandom_range(0, 1) ? (~magnitude + 1'b1) : magnitude;
         end
         2: return VALUE_WIDTH'($urandom_range(0, 40)) - VALUE_WIDTH'(20);
         default: begin
            // near the ends of the range or a power of ten
            ndigits = $urandom_range(0, 9);
            magnitude = 1;
            repeat (ndigits) magnitude = magnitude * DECIMAL_RADIX;
            case ($urandom_range(0, 2))
               0: magnitude = 32'h7FFF_FFFF - VALUE_WIDTH'($urandom_range(0, 3));
               1: magnitude = magnitude - 1'b1;
               default: ;
            endcase
            if ($urandom_range(0, 1)) begin
               return ~magnitude + 1'b1;
            end else begin
               return magnitude;
            end
         end
      endcase
   endfunction

   // response side: check every character transaction, then pick next tready
   always @(posedge clock) begin
      text_char_type owed;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_text.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h", rsp_tdata));
         end else begin
            owed = pending_text.pop_front();
            if (rsp_tdata !== owed.code) begin
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_tdata, owed.code));
            end
            if (rsp_tlast !== owed.last) begin
               report_mismatch($sformatf("tlast %b, expected %b on 0x%02h",
                                         rsp_tlast, owed.last, owed.code));
            end
         end
      end
      // random stall bursts while idling is allowed
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_hold = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      rsp_hold       = 0;
      mismatch_count = 0;
      idle_on        = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: edges of the range, zero, sign and digit count changes
      foreach (number_table[i]) begin
         send_number(number_table[i].value, number_table[i].text);
      end
      drain_text();

      // random numbers; one full drain midway and a calm tail at the end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_text();
         if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
         send_number(pick_value(), "");
      end
      req_tvalid <= 1'b0;

      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
